// ===== rtl/rcf_pkg.sv =====
package rcf_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Operation codes carried by func
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Fixed-point layout: color in bits 14:7 of a 16-bit accumulator
    localparam int FIX_SHIFT = 7;
    localparam int ACC_W     = 16;
    localparam int COLOR_W   = 8;
    localparam int MAG_W     = 15;
    localparam int CH_NUM    = 3;

    // Channel indexes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Last bit index of the serial quotient
    localparam logic [3:0] DIV_LAST = 4'(MAG_W - 1);

endpackage

// ===== rtl/rgb_color_fade.sv =====
// Linear RGB fade with one transaction in flight at a time. A start
// transaction (func = 0, steps > 0) loads the three 8.7 fixed-point
// accumulators and computes the three per-step deltas with one shared
// restoring divider, one quotient bit per cycle: for each channel a load
// state, then the quotient bits in the divide state, and after the last
// channel a finish state. A start with steps = 0 and an advance
// transaction (func = 1) go straight from idle to the finish state. The
// result sits in an output register, so the next transaction is taken
// while the previous result still waits for out_ready; the finish cycle
// holds until that register is free.
module rgb_color_fade (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] start_red,
    input  logic [7:0] start_green,
    input  logic [7:0] start_blue,
    input  logic [7:0] stop_red,
    input  logic [7:0] stop_green,
    input  logic [7:0] stop_blue,
    input  logic [7:0] steps,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cur_red,
    output logic [7:0] cur_green,
    output logic [7:0] cur_blue,
    output logic       in_progress
);

    localparam int AW = rcf_pkg::ACC_W;
    localparam int CW = rcf_pkg::COLOR_W;
    localparam int MW = rcf_pkg::MAG_W;
    localparam int NC = rcf_pkg::CH_NUM;

    rcf_pkg::state_t state_reg, state_next;

    // Fade state
    logic [AW-1:0] acc_reg    [NC];
    logic [AW-1:0] acc_next   [NC];
    logic [AW-1:0] delta_reg  [NC];
    logic [AW-1:0] delta_next [NC];
    logic [CW-1:0] target_reg [NC];
    logic [CW-1:0] target_next[NC];
    logic [7:0]    steps_left_reg, steps_left_next;

    // Latched transaction
    logic          func_reg, func_next;
    logic [CW-1:0] start_reg  [NC];
    logic [CW-1:0] start_next [NC];
    logic [CW-1:0] stop_reg   [NC];
    logic [CW-1:0] stop_next  [NC];
    logic [7:0]    steps_reg, steps_next;

    // Divider
    logic [1:0]    ch_reg, ch_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    rem_reg, rem_next;
    logic [MW-1:0] quo_reg, quo_next;
    logic          neg_reg, neg_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] cur_reg  [NC];
    logic [CW-1:0] cur_next [NC];
    logic          in_progress_reg, in_progress_next;

    // Combinational helpers
    logic [CW-1:0] sel_start, sel_stop;
    logic [AW-1:0] diff;
    logic [AW-1:0] mag;
    logic [8:0]    shifted;
    logic [9:0]    trial;
    logic          ge;
    logic [MW-1:0] quo_step;
    logic [AW-1:0] q_ext;
    logic          commit;

    assign in_ready    = (state_reg == rcf_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cur_red     = cur_reg[rcf_pkg::CH_RED];
    assign cur_green   = cur_reg[rcf_pkg::CH_GREEN];
    assign cur_blue    = cur_reg[rcf_pkg::CH_BLUE];
    assign in_progress = in_progress_reg;

    // Signed channel difference in 8.7 and its magnitude
    always_comb
    begin
        sel_start = start_reg[ch_reg];
        sel_stop  = stop_reg[ch_reg];
        diff = {1'b0, sel_stop, 7'd0} - {1'b0, sel_start, 7'd0};
        mag  = diff[AW-1] ? AW'(16'd0 - diff) : diff;
    end

    // One restoring division step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[MW-1]};
        trial    = {1'b0, shifted} - {2'b00, steps_reg};
        ge       = ~trial[9];
        quo_step = {quo_reg[MW-2:0], ge};
        q_ext    = {1'b0, quo_step};
    end

    assign commit = (state_reg == rcf_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // Next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        delta_next       = delta_reg;
        target_next      = target_reg;
        steps_left_next  = steps_left_reg;
        func_next        = func_reg;
        start_next       = start_reg;
        stop_next        = stop_reg;
        steps_next       = steps_reg;
        ch_next          = ch_reg;
        bit_next         = bit_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        neg_next         = neg_reg;
        cur_next         = cur_reg;
        in_progress_next = in_progress_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        case (state_reg)
            rcf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    start_next = '{start_red, start_green, start_blue};
                    stop_next  = '{stop_red, stop_green, stop_blue};
                    steps_next = steps;
                    ch_next    = rcf_pkg::CH_RED;
                    if (func == rcf_pkg::FUNC_START && steps != 8'd0)
                        state_next = rcf_pkg::ST_LOAD;
                    else
                        state_next = rcf_pkg::ST_FINISH;
                end
            end

            rcf_pkg::ST_LOAD:
            begin
                rem_next   = 8'd0;
                quo_next   = mag[MW-1:0];
                neg_next   = diff[AW-1];
                bit_next   = 4'd0;
                state_next = rcf_pkg::ST_DIV;
            end

            rcf_pkg::ST_DIV:
            begin
                rem_next = ge ? trial[7:0] : shifted[7:0];
                quo_next = quo_step;
                if (bit_reg == rcf_pkg::DIV_LAST)
                begin
                    delta_next[ch_reg] = neg_reg ? AW'(16'd0 - q_ext) : q_ext;
                    if (ch_reg == rcf_pkg::CH_BLUE)
                        state_next = rcf_pkg::ST_FINISH;
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = rcf_pkg::ST_LOAD;
                    end
                end
                else
                    bit_next = bit_reg + 4'd1;
            end

            rcf_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    if (func_reg == rcf_pkg::FUNC_START)
                    begin
                        // Load a new fade unless steps is zero
                        if (steps_reg != 8'd0)
                        begin
                            for (int c = 0; c < NC; c++)
                            begin
                                acc_next[c]    = {1'b0, start_reg[c], 7'd0};
                                target_next[c] = stop_reg[c];
                            end
                            steps_left_next  = steps_reg - 8'd1;
                            in_progress_next = 1'b1;
                        end
                        else
                            in_progress_next = 1'b0;
                    end
                    else if (steps_left_reg == 8'd0)
                    begin
                        // Snap to target
                        for (int c = 0; c < NC; c++)
                            acc_next[c] = {1'b0, target_reg[c], 7'd0};
                        in_progress_next = 1'b0;
                    end
                    else
                    begin
                        // Advance one step
                        for (int c = 0; c < NC; c++)
                            acc_next[c] = acc_reg[c] + delta_reg[c];
                        steps_left_next  = steps_left_reg - 8'd1;
                        in_progress_next = 1'b1;
                    end
                    for (int c = 0; c < NC; c++)
                        cur_next[c] = acc_next[c][rcf_pkg::FIX_SHIFT +: CW];
                    out_valid_next = 1'b1;
                    state_next     = rcf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rcf_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rcf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Fade state and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                acc_reg[c]    <= '0;
                delta_reg[c]  <= '0;
                target_reg[c] <= '0;
            end
            steps_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
            ch_reg          <= rcf_pkg::CH_RED;
            bit_reg         <= '0;
        end
        else
        begin
            acc_reg         <= acc_next;
            delta_reg       <= delta_next;
            target_reg      <= target_next;
            steps_left_reg  <= steps_left_next;
            out_valid_reg   <= out_valid_next;
            ch_reg          <= ch_next;
            bit_reg         <= bit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        start_reg       <= start_next;
        stop_reg        <= stop_next;
        steps_reg       <= steps_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        neg_reg         <= neg_next;
        cur_reg         <= cur_next;
        in_progress_reg <= in_progress_next;
    end

    // Divider never runs past the last channel
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcf_pkg::ST_DIV || state_reg == rcf_pkg::ST_LOAD) |-> ch_reg != 2'd3)
        else $error("channel index out of range");

    // Block is busy after taking a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready after accept");

    // A started fade leaves steps minus one to go
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && func_reg == rcf_pkg::FUNC_START && steps_reg != 8'd0)
        |=> (steps_left_reg == $past(steps_reg) - 8'd1) && in_progress_reg)
        else $error("steps left not loaded");

    // A finished advance reports done only with no steps left
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && func_reg == rcf_pkg::FUNC_ADVANCE)
        |=> out_valid_reg && (in_progress_reg || steps_left_reg == 8'd0))
        else $error("done reported with steps left");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // One fade command as presented on the input channel
    typedef struct {
        logic       func;
        logic [7:0] start_red;
        logic [7:0] start_green;
        logic [7:0] start_blue;
        logic [7:0] stop_red;
        logic [7:0] stop_green;
        logic [7:0] stop_blue;
        logic [7:0] steps;
    } fade_cmd_t;

    // One displayed color as seen on the output channel
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       busy;
    } shown_color_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       func;
    logic [7:0] start_red;
    logic [7:0] start_green;
    logic [7:0] start_blue;
    logic [7:0] stop_red;
    logic [7:0] stop_green;
    logic [7:0] stop_blue;
    logic [7:0] steps;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;
    logic       in_progress;

    rgb_color_fade dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .start_red   (start_red),
        .start_green (start_green),
        .start_blue  (start_blue),
        .stop_red    (stop_red),
        .stop_green  (stop_green),
        .stop_blue   (stop_blue),
        .steps       (steps),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cur_red     (cur_red),
        .cur_green   (cur_green),
        .cur_blue    (cur_blue),
        .in_progress (in_progress)
    );

    // Fade state mirrored by the predictor: red, green, blue in index 0..2
    logic [15:0]  fade_acc [3];
    logic [15:0]  fade_delta [3];
    logic [7:0]   fade_target [3];
    logic [7:0]   fade_left;

    shown_color_t expected_colors [$];
    int           error_count = 0;

    // Traffic shaping knobs set by each test
    bit           gaps_on = 0;
    int           burst_left = 0;
    bit           stall_on = 0;
    bit           hold_req = 0;
    int           hold_cycles = 0;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Per-step increment: ((stop<<7) - (start<<7)) / n, truncated toward zero
    function automatic logic [15:0] fade_step_size(input logic [7:0] from,
                                                   input logic [7:0] to,
                                                   input logic [7:0] n);
        int a;
        int b;
        int d;
        int q;
        a = to;
        b = from;
        d = n;
        q = ((a << 7) - (b << 7)) / d;
        return q[15:0];
    endfunction

    // Advance the mirrored state by one command and queue the color it shows
    task automatic predict_fade_step(input fade_cmd_t c);
        shown_color_t r;
        logic [7:0]   from [3];
        logic [7:0]   to [3];
        r.busy = 1'b0;
        from = '{c.start_red, c.start_green, c.start_blue};
        to   = '{c.stop_red, c.stop_green, c.stop_blue};
        if (c.func == rcf_pkg::FUNC_START) begin
            if (c.steps != 8'd0) begin
                for (int i = 0; i < 3; i++) begin
                    fade_acc[i]    = {1'b0, from[i], 7'b0};
                    fade_target[i] = to[i];
                    fade_delta[i]  = fade_step_size(from[i], to[i], c.steps);
                end
                fade_left = c.steps - 8'd1;
                r.busy = 1'b1;
            end
        end else if (fade_left == 8'd0) begin
            // Out of steps: snap to the target color
            for (int i = 0; i < 3; i++)
                fade_acc[i] = {1'b0, fade_target[i], 7'b0};
        end else begin
            fade_left = fade_left - 8'd1;
            for (int i = 0; i < 3; i++)
                fade_acc[i] = fade_acc[i] + fade_delta[i];
            r.busy = 1'b1;
        end
        r.red   = fade_acc[0][14:7];
        r.green = fade_acc[1][14:7];
        r.blue  = fade_acc[2][14:7];
        expected_colors.push_back(r);
    endtask

    // Present one transaction, wait for its handshake, then maybe pause.
    // Called and returns at a falling edge.
    task automatic send_item(input fade_cmd_t c);
        func        = c.func;
        start_red   = c.start_red;
        start_green = c.start_green;
        start_blue  = c.start_blue;
        stop_red    = c.stop_red;
        stop_green  = c.stop_green;
        stop_blue   = c.stop_blue;
        steps       = c.steps;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_fade_step(c);
        @(negedge clk);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            else begin
                burst_left = $urandom_range(0, 7);
                in_valid   = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
        end
    endtask

    function automatic fade_cmd_t random_cmd();
        fade_cmd_t c;
        c.func        = 1'($urandom);
        c.start_red   = 8'($urandom);
        c.start_green = 8'($urandom);
        c.start_blue  = 8'($urandom);
        c.stop_red    = 8'($urandom);
        c.stop_green  = 8'($urandom);
        c.stop_blue   = 8'($urandom);
        c.steps       = 8'($urandom);
        return c;
    endfunction

    task automatic start_fade(input logic [7:0] sr, input logic [7:0] sg,
                              input logic [7:0] sb, input logic [7:0] tr,
                              input logic [7:0] tg, input logic [7:0] tb,
                              input logic [7:0] n);
        fade_cmd_t c;
        c = '{rcf_pkg::FUNC_START, sr, sg, sb, tr, tg, tb, n};
        send_item(c);
    endtask

    // Advance carries random payload, which the block must ignore
    task automatic advance_fade(input int count);
        fade_cmd_t c;
        repeat (count) begin
            c = random_cmd();
            c.func = rcf_pkg::FUNC_ADVANCE;
            send_item(c);
        end
    endtask

    // Mixed traffic: mostly complete fades, some noise and cut-short fades
    task automatic run_fade_traffic(input int n_items);
        fade_cmd_t c;
        int        sent;
        int        pick;
        int        n_adv;
        sent = 0;
        while (sent < n_items) begin
            c = random_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                c.func = rcf_pkg::FUNC_START;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    c.steps = 8'($urandom_range(1, 10));
                else if (pick < 96)
                    c.steps = 8'($urandom_range(11, 40));
                else
                    c.steps = 8'($urandom_range(41, 255));
                send_item(c);
                // Sometimes cut the fade short, usually run to the end or a bit past it
                if ($urandom_range(0, 4) == 0)
                    n_adv = $urandom_range(0, c.steps);
                else
                    n_adv = c.steps + $urandom_range(0, 2);
                advance_fade(n_adv);
                sent += 1 + n_adv;
            end
            else if (pick < 90) begin
                advance_fade(1);
                sent++;
            end
            else begin
                // Ignored start: does not count toward the total
                c.func  = rcf_pkg::FUNC_START;
                c.steps = 8'd0;
                send_item(c);
            end
        end
    endtask

    task automatic test_directed();
        gaps_on  = 0;
        stall_on = 0;
        // Advance straight out of reset snaps to black
        advance_fade(1);
        // Zero-step start is ignored
        start_fade(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'd0);
        // Single-step fade from black to white, then repeated snaps
        start_fade(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd1);
        advance_fade(2);
        // Longest fade, downward
        start_fade(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'd255);
        advance_fade(2);
        // Ignored start while a fade runs keeps the current color
        start_fade(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'd0);
        advance_fade(1);
        // Mixed directions, run to the end
        start_fade(8'd10, 8'd200, 8'd128, 8'd250, 8'd3, 8'd128, 8'd4);
        advance_fade(4);
        start_fade(8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0, 8'd128);
        advance_fade(2);
        // Small negative delta that truncates toward zero
        start_fade(8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd200);
        advance_fade(2);
    endtask

    task automatic test_idle_traffic();
        gaps_on  = 1;
        stall_on = 1;
        run_fade_traffic(400);
    endtask

    task automatic test_output_backpressure();
        gaps_on     = 0;
        stall_on    = 0;
        hold_cycles = 400;
        hold_req    = 1;
        run_fade_traffic(30);
        while (hold_req) @(negedge clk);
    endtask

    task automatic test_full_rate();
        gaps_on  = 0;
        stall_on = 0;
        run_fade_traffic(350);
    endtask

    // Receiver: long hold-off on request, else a rotating stall pattern
    initial begin
        logic [7:0] ready_pat;
        int         pat_age;
        ready_pat = 8'hFF;
        pat_age   = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (hold_cycles - 1) @(negedge clk);
                hold_req = 0;
            end
            else if (stall_on) begin
                if (pat_age == 0) begin
                    ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    pat_age   = 64;
                end
                pat_age--;
                ready_pat = {ready_pat[0], ready_pat[7:1]};
                out_ready = ready_pat[0];
            end
            else begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transaction with the oldest expected color
    always @(posedge clk) begin : check_results
        shown_color_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %h %h %b",
                         $time, cur_red, cur_green, cur_blue, in_progress);
                error_count++;
            end
            else begin
                want = expected_colors.pop_front();
                check_field("cur_red", want.red, cur_red);
                check_field("cur_green", want.green, cur_green);
                check_field("cur_blue", want.blue, cur_blue);
                check_field("in_progress", {7'b0, want.busy}, {7'b0, in_progress});
            end
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = rcf_pkg::FUNC_START;
        start_red   = 8'h00;
        start_green = 8'h00;
        start_blue  = 8'h00;
        stop_red    = 8'h00;
        stop_green  = 8'h00;
        stop_blue   = 8'h00;
        steps       = 8'h00;
        for (int i = 0; i < 3; i++) begin
            fade_acc[i]    = 16'h0000;
            fade_delta[i]  = 16'h0000;
            fade_target[i] = 8'h00;
        end
        fade_left = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_idle_traffic();
        test_output_backpressure();
        test_full_rate();

        // Drain: stop offering, wait for every expected color, then settle
        in_valid = 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
